/* rtl/cansd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_pkg
// Shared types, register map and constants of the CAN signal decoder.
// ----------------------------------------------------------------------------
package cansd_pkg;

  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned AddrWidth    = 6;
  localparam int unsigned DataWidth    = 64;
  localparam int unsigned SumWidth     = 98;

  typedef enum logic [2:0] {
    RegByteOrder   = 3'd0,
    RegValueSigned = 3'd1,
    RegStartBit    = 3'd2,
    RegSignalSize  = 3'd3,
    RegScaleFactor = 3'd4,
    RegScaleOffset = 3'd5
  } cansd_reg_e;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  payload_length;
  } cansd_in_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [63:0] physical_value;
    logic               saturated;
  } cansd_out_t;

  typedef struct packed {
    logic               byte_order;
    logic               value_signed;
    logic [5:0]         start_bit;
    logic [6:0]         signal_size;
    logic signed [31:0] scale_factor;
    logic signed [47:0] scale_offset;
  } cansd_cfg_t;

endpackage

/* rtl/cansd_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_regs
// APB configuration registers: signal layout and scaling.
// ----------------------------------------------------------------------------
module cansd_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cansd_pkg::AddrWidth-1:0]        paddr,
  input  logic [cansd_pkg::DataWidth-1:0]        pwdata,
  output logic [cansd_pkg::DataWidth-1:0]        prdata,
  output logic                                   pready,
  output cansd_pkg::cansd_cfg_t                  cfg_o
);
  import cansd_pkg::*;

  cansd_cfg_t cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[5:3];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_order   <= 1'b1;
      cfg_q.value_signed <= 1'b0;
      cfg_q.start_bit    <= 6'd0;
      cfg_q.signal_size  <= 7'd8;
      cfg_q.scale_factor <= 32'sd65536;
      cfg_q.scale_offset <= 48'sd0;
    end else if (wr_en) begin
      unique case (idx)
        RegByteOrder:   cfg_q.byte_order   <= pwdata[0];
        RegValueSigned: cfg_q.value_signed <= pwdata[0];
        RegStartBit:    cfg_q.start_bit    <= pwdata[5:0];
        RegSignalSize:  cfg_q.signal_size  <= pwdata[6:0];
        RegScaleFactor: cfg_q.scale_factor <= pwdata[31:0];
        RegScaleOffset: cfg_q.scale_offset <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegByteOrder:   prdata = {63'd0, cfg_q.byte_order};
      RegValueSigned: prdata = {63'd0, cfg_q.value_signed};
      RegStartBit:    prdata = {58'd0, cfg_q.start_bit};
      RegSignalSize:  prdata = {57'd0, cfg_q.signal_size};
      RegScaleFactor: prdata = {32'd0, cfg_q.scale_factor};
      RegScaleOffset: prdata = {16'd0, cfg_q.scale_offset};
      default:        prdata = '0;
    endcase
  end

endmodule

/* rtl/cansd_extract.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_extract
// Two-stage signal extraction: length mask and shift, then size mask and
// sign extension.
// ----------------------------------------------------------------------------
module cansd_extract (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cansd_pkg::cansd_cfg_t cfg_i,
  input  logic                  valid_i,
  input  cansd_pkg::cansd_in_t  item_i,
  output logic                  valid_o,
  output logic [63:0]           raw_o,
  output logic                  neg_o
);
  import cansd_pkg::*;

  logic [3:0]  len_c;
  logic [63:0] data_m;
  logic [63:0] data_sw;
  logic [5:0]  seq_pos;
  logic [63:0] sh_d;
  logic [63:0] sh_q;
  logic        s1_valid_q;
  logic        s2_valid_q;

  logic [6:0]  size_c;
  logic [6:0]  mot_sh;
  logic [5:0]  sign_idx;
  logic [63:0] size_mask;
  logic [63:0] raw_u;
  logic        neg_d;
  logic [63:0] raw_d;
  logic [63:0] raw_q;
  logic        neg_q;

  // Stage 1: drop bytes past the length, align the signal at bit 0 (Intel)
  // or at bit 63 in sequential order (Motorola).
  always_comb begin
    len_c = (item_i.payload_length > 4'(PayloadBytes)) ? 4'(PayloadBytes)
                                                      : item_i.payload_length;
    for (int i = 0; i < 8; i++) begin
      data_m[8*i +: 8]        = (4'(i) < len_c) ? item_i.payload[8*i +: 8] : 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      data_sw[8*i +: 8] = data_m[8*(7-i) +: 8];
    end
    seq_pos = {cfg_i.start_bit[5:3], ~cfg_i.start_bit[2:0]};
    sh_d    = cfg_i.byte_order ? (data_m >> cfg_i.start_bit) : (data_sw << seq_pos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    raw_q <= raw_d;
    neg_q <= neg_d;
  end

  // Stage 2: trim to the signal size and sign-extend.
  always_comb begin
    size_c    = (cfg_i.signal_size > 7'd64) ? 7'd64 : cfg_i.signal_size;
    mot_sh    = 7'd64 - size_c;
    sign_idx  = 6'(size_c - 7'd1);
    size_mask = size_c[6] ? {64{1'b1}} : ((64'd1 << size_c[5:0]) - 64'd1);
    if (size_c == 7'd0) begin
      raw_u = '0;
    end else if (cfg_i.byte_order) begin
      raw_u = sh_q & size_mask;
    end else begin
      raw_u = sh_q >> mot_sh[5:0];
    end
    neg_d = cfg_i.value_signed && (size_c != 7'd0) && raw_u[sign_idx];
    raw_d = neg_d ? (raw_u | ~size_mask) : raw_u;
  end

  assign valid_o = s2_valid_q;
  assign raw_o   = raw_q;
  assign neg_o   = neg_q;

`ifndef SYNTH
  a_unsigned_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !cfg_i.value_signed && cfg_i.signal_size < 7'd64)
      |-> ((raw_q >> cfg_i.signal_size[5:0]) == 64'd0))
    else $error("unsigned raw value has bits above the signal size");
`endif

endmodule

/* rtl/cansd_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_scale
// Three-stage scaling: partial products, sum with offset, saturation.
// ----------------------------------------------------------------------------
module cansd_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cansd_pkg::cansd_cfg_t  cfg_i,
  input  logic                   valid_i,
  input  logic [63:0]            raw_i,
  input  logic                   neg_i,
  output logic                   valid_o,
  output cansd_pkg::cansd_out_t  res_o
);
  import cansd_pkg::*;

  logic                       s3_valid_q;
  logic                       s4_valid_q;
  logic                       s5_valid_q;
  logic signed [64:0]         plo_d;
  logic signed [64:0]         phi_d;
  logic signed [64:0]         plo_q;
  logic signed [64:0]         phi_q;
  logic [63:0]                raw3_q;
  logic [63:0]                raw4_q;
  logic signed [SumWidth-1:0] sum_d;
  logic signed [SumWidth-1:0] sum_q;
  cansd_out_t                 res_d;
  cansd_out_t                 res_q;
  logic                       fits;

  // Stage 3: low and high halves of raw times factor.
  always_comb begin
    plo_d = $signed({1'b0, raw_i[31:0]}) * cfg_i.scale_factor;
    phi_d = $signed({neg_i, raw_i[63:32]}) * cfg_i.scale_factor;
  end

  // Stage 4: combine halves and add the offset.
  always_comb begin
    sum_d = ($signed(SumWidth'(phi_q)) <<< 32) + $signed(SumWidth'(plo_q))
          + $signed(SumWidth'(cfg_i.scale_offset));
  end

  // Stage 5: clip to the signed 64-bit range.
  always_comb begin
    fits                 = (sum_q[SumWidth-1:63] == '0) || (sum_q[SumWidth-1:63] == '1);
    res_d.raw_value      = raw4_q;
    res_d.saturated      = !fits;
    if (fits) begin
      res_d.physical_value = sum_q[63:0];
    end else if (sum_q[SumWidth-1]) begin
      res_d.physical_value = {1'b1, 63'd0};
    end else begin
      res_d.physical_value = {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    raw3_q <= raw_i;
    sum_q  <= sum_d;
    raw4_q <= raw3_q;
    res_q  <= res_d;
  end

  assign valid_o = s5_valid_q;
  assign res_o   = res_q;

`ifndef SYNTH
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_valid_q && res_q.saturated)
      |-> (res_q.physical_value == {1'b1, 63'd0}
           || res_q.physical_value == {1'b0, {63{1'b1}}}))
    else $error("saturated result is not a range limit");
  a_raw_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |=> (res_q.raw_value == $past(raw4_q)))
    else $error("raw value lost alignment with its product");
`endif

endmodule

/* rtl/can_signal_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_decoder
// Extracts one DBC signal from a CAN payload and scales it to Q47.16.
// Throughput: one item per cycle; busy_o stays low, the five-stage pipeline
// (shift, trim, multiply, add, clip) never stalls since results cannot wait.
// Reset: clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module can_signal_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  cansd_pkg::cansd_in_t              item_i,
  output logic                              res_valid_o,
  output cansd_pkg::cansd_out_t             res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cansd_pkg::AddrWidth-1:0]   paddr,
  input  logic [cansd_pkg::DataWidth-1:0]   pwdata,
  output logic [cansd_pkg::DataWidth-1:0]   prdata,
  output logic                              pready
);
  import cansd_pkg::*;

  cansd_cfg_t  cfg;
  logic        acc;
  logic        ext_valid;
  logic [63:0] ext_raw;
  logic        ext_neg;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  cansd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cansd_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (acc),
    .item_i  (item_i),
    .valid_o (ext_valid),
    .raw_o   (ext_raw),
    .neg_o   (ext_neg)
  );

  cansd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (ext_valid),
    .raw_i   (ext_raw),
    .neg_i   (ext_neg),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(acc, 5))
    else $error("result strobe without an item five cycles earlier");
`endif

endmodule

/* tb/can_signal_decoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_decoder_test
// Self-checking bench for the CAN signal decoder. A queue of CAN frames feeds
// a driver; each accepted frame is decoded by a local signal predictor and
// the expected raw value, physical value and clip flag are checked in order
// against the result strobes. Directed frames cover length and size limits,
// both bit orders and the scaling extremes; random phases follow, each under
// its own register setting written over the APB port while the block is idle.
// ----------------------------------------------------------------------------
module can_signal_decoder_test;
  import cansd_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned RandPhases  = 16;
  localparam int unsigned PhaseFrames = 112;
  localparam int unsigned MaxReports  = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  cansd_in_t            frame = '0;
  logic                 res_valid;
  cansd_out_t           res;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  cansd_in_t   frame_q[$];
  cansd_out_t  decoded_q[$];
  cansd_out_t  decoded_head;
  cansd_cfg_t  cfg_shadow;
  int unsigned idle_left = 0;
  int unsigned idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  can_signal_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (frame),
    .res_valid_o (res_valid),
    .res_o       (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cansd_out_t decode_signal(cansd_cfg_t c, cansd_in_t f);
    logic [63:0]         data;
    logic [63:0]         raw;
    int unsigned         len;
    int unsigned         size;
    int unsigned         seq;
    int unsigned         pos;
    logic                neg;
    logic signed [129:0] rv;
    logic signed [129:0] fv;
    logic signed [129:0] ov;
    logic signed [129:0] sum;
    cansd_out_t          r;
    data = f.payload;
    len = (f.payload_length > PayloadBytes) ? PayloadBytes : f.payload_length;
    if (len < 8) data &= (64'd1 << (8 * len)) - 64'd1;
    size = (c.signal_size > 64) ? 64 : c.signal_size;
    raw = '0;
    if (c.byte_order) begin
      for (int unsigned k = 0; k < size; k++) begin
        pos = c.start_bit + k;
        if (pos <= 63) raw[k] = data[pos];
      end
    end else begin
      seq = (c.start_bit / 8) * 8 + 7 - (c.start_bit % 8);
      for (int unsigned k = 0; k < size; k++) begin
        pos = seq + k;
        if (pos <= 63) raw[size - 1 - k] = data[(pos / 8) * 8 + 7 - (pos % 8)];
      end
    end
    neg = 1'b0;
    if (c.value_signed && size >= 1 && raw[size - 1]) begin
      if (size < 64) raw |= ~((64'd1 << size) - 64'd1);
      neg = 1'b1;
    end
    rv = neg ? {{66{1'b1}}, raw} : {66'd0, raw};
    fv = {{98{c.scale_factor[31]}}, c.scale_factor};
    ov = {{82{c.scale_offset[47]}}, c.scale_offset};
    sum = rv * fv + ov;
    r.raw_value = raw;
    if (sum[129:63] == {67{sum[63]}}) begin
      r.physical_value = sum[63:0];
      r.saturated = 1'b0;
    end else begin
      r.physical_value = sum[129] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      r.saturated = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MaxReports) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  // driver: hold a frame until accepted, then advance or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) decoded_q.insert(decoded_q.size(), decode_signal(cfg_shadow, frame));
      if (!(start && busy)) begin
        if (idle_left != 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (frame_q.size() != 0) begin
          start <= 1'b1;
          frame <= frame_q.pop_front();
          if ($urandom_range(0, 99) < idle_pct) idle_left = $urandom_range(1, 5);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && res_valid) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item raw=%h", res.raw_value));
      end else begin
        decoded_head = decoded_q.pop_front();
        if (res.raw_value !== decoded_head.raw_value)
          report_mismatch($sformatf("raw_value %h, want %h",
                                    res.raw_value, decoded_head.raw_value));
        if (res.physical_value !== decoded_head.physical_value)
          report_mismatch($sformatf("physical_value %h, want %h",
                                    res.physical_value, decoded_head.physical_value));
        if (res.saturated !== decoded_head.saturated)
          report_mismatch($sformatf("saturated %b, want %b",
                                    res.saturated, decoded_head.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic settle();
    @(negedge clk);
    while (frame_q.size() != 0 || start || decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(input cansd_reg_e idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegByteOrder:   cfg_shadow.byte_order = val[0];
      RegValueSigned: cfg_shadow.value_signed = val[0];
      RegStartBit:    cfg_shadow.start_bit = val[5:0];
      RegSignalSize:  cfg_shadow.signal_size = val[6:0];
      RegScaleFactor: cfg_shadow.scale_factor = val[31:0];
      RegScaleOffset: cfg_shadow.scale_offset = val[47:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input cansd_cfg_t c);
    settle();
    apb_write(RegByteOrder, {63'd0, c.byte_order});
    apb_write(RegValueSigned, {63'd0, c.value_signed});
    apb_write(RegStartBit, {58'd0, c.start_bit});
    apb_write(RegSignalSize, {57'd0, c.signal_size});
    apb_write(RegScaleFactor, {32'd0, c.scale_factor});
    apb_write(RegScaleOffset, {16'd0, c.scale_offset});
    @(negedge clk);
  endtask

  task automatic add_frame(input logic [63:0] p, input logic [3:0] l);
    cansd_in_t f;
    f.payload = p;
    f.payload_length = l;
    frame_q.insert(frame_q.size(), f);
  endtask

  function automatic cansd_cfg_t rand_config();
    cansd_cfg_t c;
    logic signed [31:0] fac;
    logic signed [47:0] off;
    c.byte_order = 1'($urandom_range(0, 1));
    c.value_signed = 1'($urandom_range(0, 1));
    c.start_bit = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 9))
      0:       c.signal_size = $urandom_range(0, 1) ? 7'd64 : 7'd1;
      1:       c.signal_size = 7'($urandom_range(0, 127));
      default: c.signal_size = 7'($urandom_range(1, 64));
    endcase
    case ($urandom_range(0, 5))
      0:       fac = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       fac = $urandom;
      default: begin
        fac = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1)) fac = -fac;
      end
    endcase
    case ($urandom_range(0, 5))
      0:       off = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      1:       off = 48'({$urandom, $urandom});
      default: begin
        off = 48'($urandom_range(0, 1 << 24));
        if ($urandom_range(0, 1)) off = -off;
      end
    endcase
    c.scale_factor = fac;
    c.scale_offset = off;
    return c;
  endfunction

  initial begin
    cfg_shadow = cansd_cfg_t'{byte_order: 1'b1, value_signed: 1'b0, start_bit: 6'd0,
                              signal_size: 7'd8, scale_factor: 32'h0001_0000,
                              scale_offset: 48'd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 30;

    // reset setting: length limits
    add_frame('1, 4'd8);
    add_frame('0, 4'd0);
    add_frame('1, 4'd0);
    add_frame('1, 4'd15);
    add_frame(64'hA5A5_A5A5_A5A5_A5A5, 4'd3);
    add_frame(64'h0123_4567_89AB_CDEF, 4'd9);

    // unsigned 64-bit big-endian with largest factor and offset
    load_config(cansd_cfg_t'{byte_order: 1'b0, value_signed: 1'b0, start_bit: 6'd7,
                             signal_size: 7'd64, scale_factor: 32'h7FFF_FFFF,
                             scale_offset: 48'h7FFF_FFFF_FFFF});
    add_frame('1, 4'd8);
    add_frame(64'h80, 4'd1);
    add_frame('0, 4'd8);

    // signed 64-bit little-endian with most negative factor and offset
    load_config(cansd_cfg_t'{byte_order: 1'b1, value_signed: 1'b1, start_bit: 6'd0,
                             signal_size: 7'd64, scale_factor: 32'h8000_0000,
                             scale_offset: 48'h8000_0000_0000});
    add_frame(64'h8000_0000_0000_0000, 4'd8);
    add_frame('1, 4'd8);
    add_frame(64'h7FFF_FFFF_FFFF_FFFF, 4'd8);

    // oversized signal running past the payload end
    load_config(cansd_cfg_t'{byte_order: 1'b1, value_signed: 1'b1, start_bit: 6'd60,
                             signal_size: 7'd127, scale_factor: 32'h0001_0000,
                             scale_offset: 48'd0});
    add_frame('1, 4'd8);
    add_frame('1, 4'd7);

    // zero-size signal
    load_config(cansd_cfg_t'{byte_order: 1'b0, value_signed: 1'b1, start_bit: 6'd63,
                             signal_size: 7'd0, scale_factor: 32'hFFFF_0000,
                             scale_offset: 48'hFFFF_FFFF_FFFF});
    add_frame('1, 4'd8);
    add_frame('0, 4'd8);

    // big-endian signal crossing byte boundaries
    load_config(cansd_cfg_t'{byte_order: 1'b0, value_signed: 1'b1, start_bit: 6'd0,
                             signal_size: 7'd12, scale_factor: 32'hFFFF_0000,
                             scale_offset: 48'h0000_0001_0000});
    add_frame(64'h0000_0000_00E0_FF01, 4'd8);
    add_frame(64'h0000_0000_00E0_FF01, 4'd2);
    add_frame(64'h1, 4'd8);

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      load_config(rand_config());
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (ph == RandPhases - 1) idle_pct = 0;
      for (int unsigned n = 0; n < PhaseFrames; n++)
        add_frame({$urandom, $urandom},
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8);
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cansd_pkg.sv
rtl/cansd_regs.sv
rtl/cansd_extract.sv
rtl/cansd_scale.sv
rtl/can_signal_decoder.sv
tb/can_signal_decoder_test.sv
